### rtl/core/distinct_hue_palette_generator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distinct hue palette generator
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_HUE_PALETTE_GENERATOR_CORE_MACROS_SVH
`define DISTINCT_HUE_PALETTE_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define DHPG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dhpg check failed");

// next-cycle implication
`define DHPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dhpg check failed");

`endif

### rtl/core/dhpg_pkg.sv
// ----------------------------------------------------------------------------
// dhpg_pkg
// Types, constants and codes shared by the palette generator modules.
// ----------------------------------------------------------------------------
package dhpg_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int IDX_W   = 8;
  localparam int CH_W    = 8;
  localparam int CNT_W   = 9;
  localparam int PASS_W  = 4;
  localparam int STEP_W  = 8;
  localparam int HUE_W   = 16;
  localparam int SECT_W  = 3;

  // hue numerator and divide-by-five reciprocal
  localparam int NUM_W   = 25;
  localparam int DIV5_SH = 27;
  localparam logic [NUM_W-1:0] DIV5_MUL = 25'd26843546;
  localparam logic [NUM_W-1:0] PASS0_LEN = 25'd5;

  // channel arithmetic
  localparam int SPAN_W  = 17;
  localparam int Y_W     = 24;
  localparam int Y_SH    = 14;
  localparam int Z_W     = 10;
  localparam int ZD_SH   = 10;
  localparam logic [SPAN_W-1:0] SPAN   = 17'd81920;
  localparam logic [SPAN_W-1:0] T_BASE = 17'd16384;
  localparam logic [CH_W-1:0]   CH_V   = 8'd204;
  localparam logic [CH_W-1:0]   CH_P   = 8'd40;
  localparam logic [CH_W-1:0]   ZD_MUL = 8'd205;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_req_t;

  typedef enum logic [1:0] {
    ST_STORED,
    ST_NEW,
    ST_BEYOND,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_HUE,
    S_CONV,
    S_MIX
  } state_t;

endpackage

### rtl/core/distinct_hue_palette_generator_core.sv
// ----------------------------------------------------------------------------
// distinct_hue_palette_generator_core
// Colour table lookup and on-demand generation of well-spread hues.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item gives one
// result, shown for exactly one cycle with out_valid high; it cannot be held
// off. A rejected index (beyond count, or table full) answers in the cycle
// after the item with busy staying low. A stored index answers through the
// registered read of the colour table and the output register; busy is high
// for one cycle. Generating a new colour goes through the hue multiply,
// channel multiply, divide and table write, with busy high throughout. A new
// item can be taken in the cycle its predecessor's result is shown. The table
// holds up to min(TABLE_DEPTH, 256) colours and needs no clearing after reset.
module distinct_hue_palette_generator_core import dhpg_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [IDX_W-1:0] in_color_index,
  output logic             out_valid,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue,
  output logic [1:0]       out_status
);

  localparam int IDX_SPAN  = 1 << IDX_W;
  localparam int MEM_DEPTH = (TABLE_DEPTH < IDX_SPAN) ? TABLE_DEPTH : IDX_SPAN;
  localparam int AW        = $clog2(MEM_DEPTH);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  rgb_t             out_rgb_r, out_rgb_nxt;
  status_t          out_status_r, out_status_nxt;
  tbl_req_t         tbl_req;
  logic             advance;
  logic             accept;
  logic             is_lookup;
  logic             is_gen;
  logic             table_full;
  logic [HUE_W-1:0] hue;
  rgb_t             gen_rgb;
  rgb_t             rd_rgb;

  assign accept     = start && (state_r == S_IDLE);
  assign is_lookup  = CNT_W'(in_color_index) < count_r;
  assign is_gen     = CNT_W'(in_color_index) == count_r;
  assign table_full = int'(count_r) >= TABLE_DEPTH;

  dhpg_hue u_hue (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .hue     (hue)
  );

  dhpg_rgb u_rgb (
    .clk (clk),
    .hue (hue),
    .rgb (gen_rgb)
  );

  dhpg_table #(.DEPTH(MEM_DEPTH)) u_table (
    .clk     (clk),
    .req     (tbl_req),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (gen_rgb),
    .rd_addr (in_color_index[AW-1:0]),
    .rd_data (rd_rgb)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_lookup) begin
            state_nxt = S_RDATA;
          end else if (is_gen && !table_full) begin
            state_nxt = S_HUE;
          end
        end
      end
      S_RDATA: state_nxt = S_IDLE;
      S_HUE:   state_nxt = S_CONV;
      S_CONV:  state_nxt = S_MIX;
      S_MIX:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt  = 1'b0;
    out_rgb_nxt    = out_rgb_r;
    out_status_nxt = out_status_r;
    tbl_req        = '0;
    advance        = 1'b0;
    count_nxt      = count_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_lookup) begin
            tbl_req.rd_en = 1'b1;
          end else if (!is_gen || table_full) begin
            out_valid_nxt  = 1'b1;
            out_rgb_nxt    = '0;
            out_status_nxt = is_gen ? ST_FULL : ST_BEYOND;
          end
        end
      end
      S_RDATA: begin
        out_valid_nxt  = 1'b1;
        out_rgb_nxt    = rd_rgb;
        out_status_nxt = ST_STORED;
      end
      S_MIX: begin
        tbl_req.wr_en  = 1'b1;
        advance        = 1'b1;
        count_nxt      = count_r + 1'b1;
        out_valid_nxt  = 1'b1;
        out_rgb_nxt    = gen_rgb;
        out_status_nxt = ST_NEW;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rgb_r    <= out_rgb_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_red    = out_rgb_r.red;
  assign out_green  = out_rgb_r.green;
  assign out_blue   = out_rgb_r.blue;
  assign out_status = out_status_r;

endmodule

### rtl/core/dhpg_table.sv
// ----------------------------------------------------------------------------
// dhpg_table
// Colour table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dhpg_table import dhpg_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  tbl_req_t                 req,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rgb_t                     wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rgb_t                     rd_data
);

  rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/dhpg_hue.sv
// ----------------------------------------------------------------------------
// dhpg_hue
// Subdivision hue sequencer: pass and step counters, hue by reciprocal multiply.
// ----------------------------------------------------------------------------
module dhpg_hue import dhpg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  output logic [HUE_W-1:0] hue
);

  logic [PASS_W-1:0]  pass_r, pass_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [STEP_W-1:0]  step_inc;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   lim;
  logic [2*NUM_W-1:0] prod_r;

  always_comb begin
    if (pass_r == '0) begin
      num = NUM_W'({step_r, {HUE_W{1'b0}}});
      lim = PASS0_LEN;
    end else begin
      num = {step_r, 1'b1, {HUE_W{1'b0}}} >> pass_r;
      lim = PASS0_LEN << (pass_r - 1'b1);
    end
  end

  assign step_inc = step_r + 1'b1;

  always_comb begin
    pass_nxt = pass_r;
    step_nxt = step_r;
    if (advance) begin
      if (NUM_W'(step_inc) == lim) begin
        pass_nxt = pass_r + 1'b1;
        step_nxt = '0;
      end else begin
        step_nxt = step_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= '0;
      step_r <= '0;
    end else begin
      pass_r <= pass_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= num * DIV5_MUL;
  end

  assign hue = prod_r[DIV5_SH +: HUE_W];

endmodule

### rtl/core/dhpg_rgb.sv
// ----------------------------------------------------------------------------
// dhpg_rgb
// Six-sector hue to RGB conversion at saturation and value 0.8.
// ----------------------------------------------------------------------------
module dhpg_rgb import dhpg_pkg::*; (
  input  logic             clk,
  input  logic [HUE_W-1:0] hue,
  output rgb_t             rgb
);

  logic [HUE_W+2:0]    h6;
  logic [HUE_W-1:0]    frac;
  logic [SPAN_W-1:0]   span_q, span_t;
  logic [SECT_W-1:0]   sect_r;
  logic [Y_W-1:0]      yq_r, yt_r;
  logic [Z_W+CH_W-1:0] pq, pt;
  logic [CH_W-1:0]     q, t;

  assign h6     = (HUE_W+3)'({hue, 2'b00}) + (HUE_W+3)'({hue, 1'b0});
  assign frac   = h6[HUE_W-1:0];
  assign span_q = SPAN - SPAN_W'(frac);
  assign span_t = T_BASE + SPAN_W'(frac);

  always_ff @(posedge clk) begin
    sect_r <= h6[HUE_W+2:HUE_W];
    yq_r   <= Y_W'(span_q) * Y_W'(CH_V);
    yt_r   <= Y_W'(span_t) * Y_W'(CH_V);
  end

  // drop 2^14, then divide by five
  assign pq = (Z_W+CH_W)'(yq_r[Y_W-1:Y_SH]) * (Z_W+CH_W)'(ZD_MUL);
  assign pt = (Z_W+CH_W)'(yt_r[Y_W-1:Y_SH]) * (Z_W+CH_W)'(ZD_MUL);
  assign q  = pq[ZD_SH +: CH_W];
  assign t  = pt[ZD_SH +: CH_W];

  always_comb begin
    case (sect_r)
      3'd0:    rgb = {CH_V, t, CH_P};
      3'd1:    rgb = {q, CH_V, CH_P};
      3'd2:    rgb = {CH_P, CH_V, t};
      3'd3:    rgb = {CH_P, q, CH_V};
      3'd4:    rgb = {t, CH_P, CH_V};
      default: rgb = {CH_V, CH_P, q};
    endcase
  end

endmodule

### rtl/core/dhpg_checker.sv
// ----------------------------------------------------------------------------
// dhpg_checker
// Port-level checks on the palette generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "distinct_hue_palette_generator_core_macros.svh"

module dhpg_checker import dhpg_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [CH_W-1:0]  out_red,
  input logic [CH_W-1:0]  out_green,
  input logic [CH_W-1:0]  out_blue,
  input logic [1:0]       out_status
);

  `DHPG_ASSERT_NEXT(a_accept_answered, start && !busy, busy || out_valid)
  `DHPG_ASSERT_NOW(a_done_strobes, $fell(busy), out_valid)
  `DHPG_ASSERT_NOW(a_result_has_cause, out_valid, $past(start && !busy) || $fell(busy))
  `DHPG_ASSERT_NOW(a_reject_black, out_valid && (out_status == ST_BEYOND || out_status == ST_FULL), out_red == '0 && out_green == '0 && out_blue == '0)
  `DHPG_ASSERT_NOW(a_new_has_value, out_valid && out_status == ST_NEW, out_red == CH_V || out_green == CH_V || out_blue == CH_V)

endmodule

bind distinct_hue_palette_generator_core dhpg_checker u_dhpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_red    (out_red),
  .out_green  (out_green),
  .out_blue   (out_blue),
  .out_status (out_status)
);

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the palette generator core. A directed table covers the first
// colors, stored reads and rejected indexes. Random requests then fill the
// table through several subdivision passes, mixed with reads and rejects.
// Every result is checked against a directed row or a local color table model.
// ----------------------------------------------------------------------------
module tb;
  import dhpg_pkg::*;

  localparam int DEPTH     = 256;
  localparam int RAND_N    = 700;
  localparam int DIR_N     = 21;
  localparam int LIMIT     = 200000;
  localparam int SHOW_MAX  = 10;
  localparam int V_LEVEL   = 204;
  localparam int P_LEVEL   = 40;
  localparam int SPAN_FULL = 327680;

  typedef struct packed {
    rgb_t    color;
    status_t status;
  } palette_resp_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             typed;
    palette_resp_t    resp;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [IDX_W-1:0] in_color_index = '0;
  logic             busy;
  logic             out_valid;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic [1:0]       out_status;

  logic [PASS_W-1:0] pass_num = '0;
  logic [STEP_W-1:0] pass_step = '0;
  logic [CNT_W-1:0]  color_count = '0;
  rgb_t              colors [DEPTH];

  palette_resp_t pending_colors [$];
  int            bad_count = 0;
  int            cycle_count = 0;

  distinct_hue_palette_generator_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_color_index(in_color_index),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_status    (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [HUE_W-1:0] advance_hue();
    longint unsigned num;
    longint unsigned den;
    int unsigned     limit;
    logic [STEP_W-1:0] s;
    if (pass_num == 0) begin
      num   = longint'(pass_step) * 65536;
      den   = 5;
      limit = 5;
    end else begin
      num   = (2 * longint'(pass_step) + 1) * 65536;
      den   = longint'(5) << pass_num;
      limit = 5 << (pass_num - 1);
    end
    s = pass_step + 1'b1;
    if (s == limit) begin
      pass_num  = pass_num + 1'b1;
      pass_step = '0;
    end else begin
      pass_step = s;
    end
    return HUE_W'(num / den);
  endfunction

  function automatic rgb_t hue_rgb(logic [HUE_W-1:0] hue);
    int unsigned h6;
    int unsigned f;
    int unsigned q;
    int unsigned t;
    rgb_t        c;
    h6 = int'(hue) * 6;
    f  = h6 & 32'hFFFF;
    q  = (V_LEVEL * (SPAN_FULL - 4 * f)) / SPAN_FULL;
    t  = (V_LEVEL * (SPAN_FULL - 4 * (65536 - f))) / SPAN_FULL;
    case (h6 >> 16)
      0: c = '{CH_W'(V_LEVEL), CH_W'(t), CH_W'(P_LEVEL)};
      1: c = '{CH_W'(q), CH_W'(V_LEVEL), CH_W'(P_LEVEL)};
      2: c = '{CH_W'(P_LEVEL), CH_W'(V_LEVEL), CH_W'(t)};
      3: c = '{CH_W'(P_LEVEL), CH_W'(q), CH_W'(V_LEVEL)};
      4: c = '{CH_W'(t), CH_W'(P_LEVEL), CH_W'(V_LEVEL)};
      default: c = '{CH_W'(V_LEVEL), CH_W'(P_LEVEL), CH_W'(q)};
    endcase
    return c;
  endfunction

  function automatic palette_resp_t predict_palette(logic [IDX_W-1:0] idx);
    palette_resp_t r;
    r.color = '0;
    if (CNT_W'(idx) < color_count) begin
      r.color  = colors[idx];
      r.status = ST_STORED;
    end else if (CNT_W'(idx) == color_count) begin
      if (color_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        r.color             = hue_rgb(advance_hue());
        colors[color_count] = r.color;
        color_count         = color_count + 1'b1;
        r.status            = ST_NEW;
      end
    end else begin
      r.status = ST_BEYOND;
    end
    return r;
  endfunction

  function automatic dir_row_t dir_row(int n);
    dir_row_t d;
    d = '{8'd0, 1'b0, '{'0, ST_NEW}};
    case (n)
      0:  d = '{8'd0,   1'b1, '{'{8'd204, 8'd40, 8'd40}, ST_NEW}};
      1:  d = '{8'd0,   1'b1, '{'{8'd204, 8'd40, 8'd40}, ST_STORED}};
      2:  d = '{8'd255, 1'b1, '{'0, ST_BEYOND}};
      3:  d.idx = 8'd1;
      4:  d.idx = 8'd2;
      5:  d.idx = 8'd3;
      6:  d.idx = 8'd4;
      7:  d = '{8'd7,   1'b1, '{'0, ST_BEYOND}};
      8:  d.idx = 8'd5;
      9:  d.idx = 8'd6;
      10: d.idx = 8'd7;
      11: d.idx = 8'd8;
      12: d.idx = 8'd9;
      13: d.idx = 8'd10;
      14: d.idx = 8'd1;
      15: d.idx = 8'd9;
      16: d = '{8'd0,   1'b1, '{'{8'd204, 8'd40, 8'd40}, ST_STORED}};
      17: d = '{8'd128, 1'b1, '{'0, ST_BEYOND}};
      18: d = '{8'h55,  1'b1, '{'0, ST_BEYOND}};
      19: d = '{8'hAA,  1'b1, '{'0, ST_BEYOND}};
      default: d.idx = 8'd11;
    endcase
    return d;
  endfunction

  task automatic send_index(input logic [IDX_W-1:0] idx, input bit may_idle,
                            input bit typed, input palette_resp_t typed_resp);
    palette_resp_t pred;
    while (may_idle && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_color_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = predict_palette(idx);
    if (typed)
      pred = typed_resp;
    pending_colors = {pending_colors, pred};
  endtask

  task automatic report_bad(input palette_resp_t want, input bit have_want);
    bad_count++;
    if (bad_count <= SHOW_MAX) begin
      if (have_want)
        $display("mismatch: want rgb %h status %0d, got rgb %h%h%h status %0d",
                 want.color, want.status, out_red, out_green, out_blue, out_status);
      else
        $display("unexpected result: rgb %h%h%h status %0d",
                 out_red, out_green, out_blue, out_status);
    end
  endtask

  always @(posedge clk) begin : check_colors
    palette_resp_t want;
    if (rst_n && out_valid) begin
      if (pending_colors.size() == 0) begin
        report_bad('0, 1'b0);
      end else begin
        want = pending_colors.pop_front();
        if (out_red != want.color.red || out_green != want.color.green ||
            out_blue != want.color.blue || out_status != want.status)
          report_bad(want, 1'b1);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL distinct_hue_palette_generator_core");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t         row;
    logic [IDX_W-1:0] idx;
    int               pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < DIR_N; n++) begin
      row = dir_row(n);
      send_index(row.idx, 1'b1, row.typed, row.resp);
    end

    for (int n = 0; n < RAND_N; n++) begin
      pick = $urandom_range(99);
      if (color_count < DEPTH && pick < 45)
        idx = color_count[IDX_W-1:0];
      else if (color_count > 0 && pick < 85)
        idx = IDX_W'($urandom_range(color_count - 1));
      else
        idx = IDX_W'($urandom_range(255));
      send_index(idx, !(n >= 250 && n < 400), 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (bad_count == 0 && pending_colors.size() == 0)
      $display("PASS distinct_hue_palette_generator_core");
    else
      $display("FAIL distinct_hue_palette_generator_core");
    $finish;
  end

endmodule

### distinct_hue_palette_generator_core.f
+incdir+rtl/core
rtl/core/dhpg_pkg.sv
rtl/core/dhpg_table.sv
rtl/core/dhpg_hue.sv
rtl/core/dhpg_rgb.sv
rtl/core/distinct_hue_palette_generator_core.sv
rtl/core/dhpg_checker.sv
sim/tb.sv
